### design/spq_pkg.sv
// shared types, codes and defaults for the sorted priority queue
package spq_pkg;

  // default number of stored jobs
  localparam int unsigned CAPACITY_DEF = 16;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // one stored job
  typedef struct packed {
    logic signed [15:0] prio;
    logic [15:0]        id;
    logic [15:0]        size;
    logic [7:0]         user;
  } entry_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic [1:0] status;
    logic       popped;
    entry_t     job;
    logic [4:0] entry_count;
    logic       is_full;
    logic       is_empty;
  } res_t;

endpackage

### design/sorted_priority_queue_top.sv
// Sorted priority queue, top level with output register.
// Jobs are kept sorted by descending priority in one circular memory of
// CAPACITY entries; equal priorities leave in arrival order. One item is
// worked on at a time. A pop reads the head entry, then reports; a pop on
// an empty queue and an insert into an empty or full queue go straight to
// the result. Any other insert scans from the tail, one stored entry per cycle
// through the single memory read port, moving each lower-priority entry one
// place back, until it stops behind a stored job or lands at the head. A
// finished result waits in the output register while the next item is
// accepted. Every item gives exactly one result with the status, the popped
// job (zero otherwise), and the count, full and empty flags after the
// operation. No clearing pass is needed after reset.
module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [15:0] in_job_priority,
  input  logic [15:0]        in_job_id,
  input  logic [15:0]        in_job_size,
  input  logic [7:0]         in_job_user,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_out_valid,
  output logic signed [15:0] out_out_priority,
  output logic [15:0]        out_out_id,
  output logic [15:0]        out_out_size,
  output logic [7:0]         out_out_user,
  output logic [4:0]         out_entry_count,
  output logic               out_is_full,
  output logic               out_is_empty
);

  entry_t        in_job;
  res_t          res;
  res_t          res_r;
  logic          res_valid;
  logic          res_take;
  logic          out_valid_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  entry_t        mem_rd;

  // input job bundle
  assign in_job.prio = in_job_priority;
  assign in_job.id   = in_job_id;
  assign in_job.size = in_job_size;
  assign in_job.user = in_job_user;

  spq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (in_cmd),
    .in_job    (in_job),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_wa    (mem_wa),
    .mem_wd    (mem_wd),
    .mem_re    (mem_re),
    .mem_ra    (mem_ra),
    .mem_rd    (mem_rd)
  );

  spq_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  // output register takes a result when empty or being drained
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      res_r <= res;
    end
  end

  // result ports
  assign out_valid        = out_valid_r;
  assign out_status       = res_r.status;
  assign out_out_valid    = res_r.popped;
  assign out_out_priority = res_r.job.prio;
  assign out_out_id       = res_r.job.id;
  assign out_out_size     = res_r.job.size;
  assign out_out_user     = res_r.job.user;
  assign out_entry_count  = res_r.entry_count;
  assign out_is_full      = res_r.is_full;
  assign out_is_empty     = res_r.is_empty;

endmodule

### design/spq_mem.sv
// entry storage: one write port, one read port, registered read data
module spq_mem import spq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/spq_ctrl.sv
// sequencer: circular sorted list in memory, pops at the head, inserts by tail scan
module spq_ctrl import spq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned SW = ((AW > CW) ? AW : CW) + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          cmd,
  input  entry_t        in_job,
  output logic          res_valid,
  input  logic          res_take,
  output res_t          res,
  output logic          mem_we,
  output logic [AW-1:0] mem_wa,
  output entry_t        mem_wd,
  output logic          mem_re,
  output logic [AW-1:0] mem_ra,
  input  entry_t        mem_rd
);

  typedef enum logic [2:0] {S_IDLE, S_POP, S_SCAN, S_PUT, S_RES} state_t;

  localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_SUM   = SW'(CAPACITY);

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] k_r, k_nxt;
  entry_t        job_r, job_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          popped_r, popped_nxt;
  entry_t        pjob_r, pjob_nxt;

  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail_addr;
  logic [AW-1:0] ptr_inc;
  logic [AW-1:0] ptr_dec;
  logic [AW-1:0] head_inc;
  logic [31:0]   count_wide;

  // physical address of the last stored entry
  always_comb begin
    tail_sum = SW'(head_r) + SW'(count_r) - SW'(1);
    if (tail_sum >= CAP_SUM) begin
      tail_sum = tail_sum - CAP_SUM;
    end
    tail_addr = tail_sum[AW-1:0];
  end

  // wrapping neighbors of the scan pointer and the head
  assign ptr_inc  = (ptr_r == LAST_ADDR) ? '0 : ptr_r + AW'(1);
  assign ptr_dec  = (ptr_r == '0) ? LAST_ADDR : ptr_r - AW'(1);
  assign head_inc = (head_r == LAST_ADDR) ? '0 : head_r + AW'(1);

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_RES);

  // result fields
  assign count_wide      = 32'(count_r);
  assign res.status      = status_r;
  assign res.popped      = popped_r;
  assign res.job         = pjob_r;
  assign res.entry_count = count_wide[4:0];
  assign res.is_full     = (count_r == CAP_CNT);
  assign res.is_empty    = (count_r == '0);

  // next state and memory accesses
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    k_nxt      = k_r;
    job_nxt    = job_r;
    status_nxt = status_r;
    popped_nxt = popped_r;
    pjob_nxt   = pjob_r;
    mem_we     = 1'b0;
    mem_wa     = ptr_inc;
    mem_wd     = job_r;
    mem_re     = 1'b0;
    mem_ra     = ptr_dec;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          job_nxt    = in_job;
          status_nxt = ST_OK;
          popped_nxt = 1'b0;
          pjob_nxt   = '0;
          if (cmd == CMD_POP) begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_RES;
            end else begin
              mem_re    = 1'b1;
              mem_ra    = head_r;
              state_nxt = S_POP;
            end
          end else if (count_r == CAP_CNT) begin
            status_nxt = ST_FULL;
            state_nxt  = S_RES;
          end else if (count_r == '0) begin
            mem_we    = 1'b1;
            mem_wa    = head_r;
            mem_wd    = in_job;
            count_nxt = count_r + CW'(1);
            state_nxt = S_RES;
          end else begin
            mem_re    = 1'b1;
            mem_ra    = tail_addr;
            ptr_nxt   = tail_addr;
            k_nxt     = count_r - CW'(1);
            state_nxt = S_SCAN;
          end
        end
      end
      S_POP: begin
        pjob_nxt   = mem_rd;
        popped_nxt = 1'b1;
        head_nxt   = head_inc;
        count_nxt  = count_r - CW'(1);
        state_nxt  = S_RES;
      end
      S_SCAN: begin
        // entry at ptr either stays (job lands behind it) or moves one down
        mem_we = 1'b1;
        mem_wa = ptr_inc;
        if (mem_rd.prio >= job_r.prio) begin
          mem_wd    = job_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_RES;
        end else begin
          mem_wd = mem_rd;
          if (k_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            mem_re  = 1'b1;
            mem_ra  = ptr_dec;
            ptr_nxt = ptr_dec;
            k_nxt   = k_r - CW'(1);
          end
        end
      end
      S_PUT: begin
        // every stored job has lower priority: new job becomes the head
        mem_we    = 1'b1;
        mem_wa    = head_r;
        mem_wd    = job_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_RES;
      end
      S_RES: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, head pointer and entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    k_r      <= k_nxt;
    job_r    <= job_nxt;
    status_r <= status_nxt;
    popped_r <= popped_nxt;
    pjob_r   <= pjob_nxt;
  end

endmodule

### sim/sorted_priority_queue_top_tb.sv
// testbench for the sorted priority queue: random and directed jobs checked against a local model
`timescale 1ns / 100ps

module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int DEPTH        = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1650;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_LEN     = 300;
  localparam int LIMIT_CYCLES = 1000000;

  // one queue operation as offered on the input channel
  typedef struct {
    logic               cmd;
    logic signed [15:0] prio;
    logic [15:0]        id;
    logic [15:0]        size;
    logic [7:0]         user;
    bit                 drain_first;
  } job_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_cmd = CMD_INSERT;
  logic signed [15:0] in_job_priority = '0;
  logic [15:0]        in_job_id = '0;
  logic [15:0]        in_job_size = '0;
  logic [7:0]         in_job_user = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic               out_out_valid;
  logic signed [15:0] out_out_priority;
  logic [15:0]        out_out_id;
  logic [15:0]        out_out_size;
  logic [7:0]         out_out_user;
  logic [4:0]         out_entry_count;
  logic               out_is_full;
  logic               out_is_empty;

  sorted_priority_queue_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_job_priority  (in_job_priority),
    .in_job_id        (in_job_id),
    .in_job_size      (in_job_size),
    .in_job_user      (in_job_user),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_out_valid    (out_out_valid),
    .out_out_priority (out_out_priority),
    .out_out_id       (out_out_id),
    .out_out_size     (out_out_size),
    .out_out_user     (out_out_user),
    .out_entry_count  (out_entry_count),
    .out_is_full      (out_is_full),
    .out_is_empty     (out_is_empty)
  );

  // model state and bookkeeping
  entry_t   sorted_jobs [DEPTH];
  int       job_count = 0;
  res_t     awaited_reports [$];
  job_req_t job_reqs [$];
  job_req_t offered_req;
  int       total_reqs = 0;
  int       n_accepted = 0;
  int       n_reports = 0;
  int       n_errors = 0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  bit       calm = 1'b0;
  int       cycle_cnt = 0;
  bit       drv_took;
  job_req_t drv_next;
  res_t     mon_want;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // apply one operation to the model queue and record the report it must produce
  function automatic void apply_job_op(job_req_t r);
    res_t rep;
    int   pos;
    int   i;
    rep = '0;
    rep.status = ST_OK;
    if (r.cmd == CMD_INSERT) begin
      if (job_count >= DEPTH) begin
        rep.status = ST_FULL;
      end else begin
        // land after every job of greater or equal priority
        pos = 0;
        while (pos < job_count && $signed(sorted_jobs[pos].prio) >= $signed(r.prio)) pos++;
        for (i = job_count; i > pos; i--) sorted_jobs[i] = sorted_jobs[i - 1];
        sorted_jobs[pos].prio = r.prio;
        sorted_jobs[pos].id   = r.id;
        sorted_jobs[pos].size = r.size;
        sorted_jobs[pos].user = r.user;
        job_count++;
      end
    end else if (job_count == 0) begin
      rep.status = ST_EMPTY;
    end else begin
      rep.popped = 1'b1;
      rep.job = sorted_jobs[0];
      for (i = 0; i + 1 < job_count; i++) sorted_jobs[i] = sorted_jobs[i + 1];
      job_count--;
    end
    rep.entry_count = job_count[4:0];
    rep.is_full = (job_count == DEPTH);
    rep.is_empty = (job_count == 0);
    awaited_reports.push_back(rep);
  endfunction

  // compare one report field
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic job_req_t make_req(logic cmd, logic [15:0] prio, logic [15:0] id,
                                        logic [15:0] size, logic [7:0] user);
    job_req_t r;
    r.cmd = cmd;
    r.prio = prio;
    r.id = id;
    r.size = size;
    r.user = user;
    r.drain_first = 1'b0;
    return r;
  endfunction

  // random job; priorities lean toward ties and extremes
  function automatic job_req_t random_req(int insert_pct);
    logic [15:0] p;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 35) p = 16'($urandom_range(0, 4) - 2);
    else if (r < 45) begin
      case ($urandom_range(0, 3))
        0: p = 16'h8000;
        1: p = 16'h7fff;
        2: p = 16'hffff;
        default: p = 16'h0000;
      endcase
    end else p = 16'($urandom());
    return make_req(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_POP, p,
                    16'($urandom()), 16'($urandom()), 8'($urandom()));
  endfunction

  // driver: offers queued items, holds them while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      drv_took = in_valid && (in_stall == 1'b0);
      if (drv_took) begin
        apply_job_op(offered_req);
        n_accepted <= n_accepted + 1;
      end
      if (in_valid && !drv_took) begin
        // stalled item stays put
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (job_reqs.size() > 0 &&
                   !(job_reqs[0].drain_first && (n_accepted + drv_took != n_reports))) begin
        drv_next = job_reqs.pop_front();
        offered_req <= drv_next;
        in_valid <= 1'b1;
        in_cmd <= drv_next.cmd;
        in_job_priority <= drv_next.prio;
        in_job_id <= drv_next.id;
        in_job_size <= drv_next.size;
        in_job_user <= drv_next.user;
        send_gap <= pick_pause();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off once traffic is under way
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each accepted report and drives random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_reports <= n_reports + 1;
        if (n_reports >= n_accepted) begin
          $display("%0t: report with nothing expected, actual status %0d count %0d",
                   $time, out_status, out_entry_count);
          n_errors++;
        end else begin
          mon_want = awaited_reports.pop_front();
          check_field("status", mon_want.status, out_status);
          check_field("out_valid", mon_want.popped, out_out_valid);
          check_field("priority", mon_want.job.prio, out_out_priority);
          check_field("id", mon_want.job.id, out_out_id);
          check_field("size", mon_want.job.size, out_out_size);
          check_field("user", mon_want.job.user, out_out_user);
          check_field("entry_count", mon_want.entry_count, out_entry_count);
          check_field("is_full", mon_want.is_full, out_is_full);
          check_field("is_empty", mon_want.is_empty, out_is_empty);
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        recv_gap <= pick_pause();
        out_stall <= (hold_left > 1);
      end
    end
  end

  // cycle limit and quiet stretches
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("%0t: timeout", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    job_req_t r;
    int       phase;
    int       len;
    int       pct;
    int       k;

    // directed: empty pop, extremes, ties, then drain past empty
    job_reqs.push_back(make_req(CMD_POP, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    job_reqs.push_back(make_req(CMD_INSERT, 16'h0000, 16'h0001, 16'h1234, 8'h11));
    job_reqs.push_back(make_req(CMD_INSERT, 16'h7fff, 16'hffff, 16'hffff, 8'hff));
    job_reqs.push_back(make_req(CMD_INSERT, 16'h8000, 16'h0000, 16'h0000, 8'h00));
    job_reqs.push_back(make_req(CMD_INSERT, 16'h0000, 16'h0002, 16'h5678, 8'h22));
    job_reqs.push_back(make_req(CMD_INSERT, 16'hffff, 16'h0003, 16'h9abc, 8'h33));
    job_reqs.push_back(make_req(CMD_INSERT, 16'h0001, 16'h0004, 16'hdef0, 8'h44));
    for (k = 0; k < 7; k++)
      job_reqs.push_back(make_req(CMD_POP, 16'hffff, 16'hffff, 16'hffff, 8'hff));

    // random: runs that fill, drain or mix, some starting only once every earlier report has arrived
    phase = 0;
    while (job_reqs.size() < RANDOM_ITEMS + 14) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: pct = 85;
        4, 5, 6, 7: pct = 15;
        default: pct = 50;
      endcase
      len = $urandom_range(10, 40);
      for (k = 0; k < len; k++) begin
        r = random_req(pct);
        if (k == 0 && phase % 20 == 0) r.drain_first = 1'b1;
        job_reqs.push_back(r);
      end
      phase++;
    end
    total_reqs = job_reqs.size();

    // reset
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < total_reqs) @(posedge clk);
    while (n_reports < n_accepted) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);
    if (awaited_reports.size() != 0) begin
      $display("%0t: %0d reports never arrived", $time, awaited_reports.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
